### design/psbp_pkg.sv
// shared constants, codes and controller/datapath interface types
package psbp_pkg;

    localparam int POOL_SIZE = 8;
    localparam int ID_W      = 3;
    localparam int CNT_W     = 16;
    localparam int SIZE_W    = 4;
    localparam int SEQ_W     = 48;
    localparam int DCNT_W    = 6;

    localparam logic [CNT_W-1:0]  PPB_RESET = 16'd1024;
    localparam logic [SIZE_W-1:0] BIU_RESET = 4'd8;
    localparam logic [SIZE_W-1:0] POOL_CNT  = 4'd8;
    localparam logic [3:0]        RETIRE_LIMIT = 4'd2;

    localparam logic [1:0] FUNC_PACKET  = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_NOP     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_ABORT   = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    localparam logic CFG_PPB = 1'b0;
    localparam logic CFG_BIU = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic abort;
        logic retire;
        logic count;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic too_far;
        logic idx_gt2;
    } t_sts;

endpackage

### design/packet_sequence_buffer_placer.sv
// buffer placer top level: controller and datapath
//
//  channel  | handshake                       | contents
//  input    | i_valid / o_stall               | func, sequence_req, released_buffer
//  output   | o_valid / i_stall               | status, slot, counts, missing, retired
//  config   | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// a packet word passes through accept, the divider steps, check, retire (0 to 5 retired buffers),
// retire exit, count and done; an aborted packet goes from check straight to done
// read, release and no-op words pass through accept, execute and done
// synchronous active-low reset restores the reset pool with no clearing pass
// a finished word waits in the output register; a new word is taken while it stalls
module packet_sequence_buffer_placer import psbp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [SEQ_W-1:0]   i_sequence_req,
    input  logic [ID_W-1:0]    i_released_buffer,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [ID_W-1:0]    o_buffer_slot,
    output logic [CNT_W-1:0]   o_packet_count,
    output logic signed [16:0] o_missing_pkts,
    output logic [2:0]         o_retired,
    output logic [SIZE_W-1:0]  o_writable_count,
    output logic [SIZE_W-1:0]  o_readable_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    psbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    psbp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_func),
        .i_sequence_req    (i_sequence_req),
        .i_released_buffer (i_released_buffer),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (o_status),
        .o_buffer_slot     (o_buffer_slot),
        .o_packet_count    (o_packet_count),
        .o_missing_pkts    (o_missing_pkts),
        .o_retired         (o_retired),
        .o_writable_count  (o_writable_count),
        .o_readable_count  (o_readable_count)
    );

endmodule

### design/psbp_ctrl.sv
// sequencing state machine for packet, read and release words
module psbp_ctrl import psbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    input  logic       i_stall,
    input  t_sts       i_sts,
    output logic       o_stall,
    output logic       o_valid,
    output logic       o_cfg_ready,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_RETIRE = 3'd3;
    localparam logic [2:0] S_COUNT  = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_free;

    assign out_free    = !r_ovalid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_func == FUNC_PACKET) ? S_DIV : S_EXEC;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.too_far) begin
                    o_cmd.abort = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RETIRE;
                end
            end
            S_RETIRE: begin
                if (i_sts.idx_gt2) o_cmd.retire = 1'b1;
                else n_state = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state = S_DONE;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid && i_stall;
        if (o_cmd.load_out) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

### design/psbp_dp.sv
// buffer queues, packet counters, divider and result registers
module psbp_dp import psbp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_func,
    input  logic [SEQ_W-1:0]   i_sequence_req,
    input  logic [ID_W-1:0]    i_released_buffer,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output logic [1:0]         o_status,
    output logic [ID_W-1:0]    o_buffer_slot,
    output logic [CNT_W-1:0]   o_packet_count,
    output logic signed [16:0] o_missing_pkts,
    output logic [2:0]         o_retired,
    output logic [SIZE_W-1:0]  o_writable_count,
    output logic [SIZE_W-1:0]  o_readable_count
);

    logic [CNT_W-1:0]  r_ppb;
    logic [ID_W-1:0]   r_wids [POOL_SIZE];
    logic [ID_W-1:0]   r_rids [POOL_SIZE];
    logic [CNT_W-1:0]  r_cnt  [POOL_SIZE];
    logic [ID_W-1:0]   r_wh, r_rh;
    logic [SIZE_W-1:0] r_ws, r_rs;
    logic [SEQ_W-1:0]  r_start;
    logic              r_abort;

    logic [1:0]        r_func;
    logic [ID_W-1:0]   r_rel;
    logic [SEQ_W-1:0]  r_dq;
    logic [CNT_W:0]    r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [2:0]        r_ret;

    logic [1:0]        r_s_status;
    logic [ID_W-1:0]   r_s_slot;
    logic [CNT_W-1:0]  r_s_count;
    logic [16:0]       r_s_missing;

    logic [CNT_W-1:0]  ppb_eff;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [ID_W-1:0]   cnt_id;
    logic [CNT_W-1:0]  cnt_new;
    logic [ID_W-1:0]   rd_id;

    assign ppb_eff   = (r_ppb == '0) ? CNT_W'(1) : r_ppb;
    assign trial     = {r_rem[CNT_W-1:0], r_dq[SEQ_W-1]};
    assign qbit      = (trial >= {1'b0, ppb_eff});
    assign cnt_id    = r_wids[r_wh + r_dq[ID_W-1:0]];
    assign cnt_new   = (r_cnt[cnt_id] == '1) ? r_cnt[cnt_id] : r_cnt[cnt_id] + 1'b1;
    assign rd_id     = r_rids[r_rh];

    assign o_sts.div_last = (r_dcnt == DCNT_W'(SEQ_W - 1));
    assign o_sts.too_far  = (|r_dq[SEQ_W-1:SIZE_W]) || (r_dq[SIZE_W-1:0] >= r_ws);
    assign o_sts.idx_gt2  = (r_dq[SIZE_W-1:0] > RETIRE_LIMIT);

    // configuration and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppb   <= PPB_RESET;
            r_wh    <= '0;
            r_ws    <= BIU_RESET;
            r_rh    <= '0;
            r_rs    <= '0;
            r_start <= '0;
            r_abort <= 1'b0;
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_wids[i] <= ID_W'(i);
                r_cnt[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PPB) begin
                r_ppb <= i_cfg_data;
            end else begin
                r_wh    <= '0;
                r_ws    <= (i_cfg_data[SIZE_W-1:0] > POOL_CNT) ? POOL_CNT
                                                               : i_cfg_data[SIZE_W-1:0];
                r_rh    <= '0;
                r_rs    <= '0;
                r_start <= '0;
                r_abort <= 1'b0;
                for (int i = 0; i < POOL_SIZE; i++) begin
                    r_wids[i] <= (SIZE_W'(i) < ((i_cfg_data[SIZE_W-1:0] > POOL_CNT) ?
                                  POOL_CNT : i_cfg_data[SIZE_W-1:0])) ? ID_W'(i) : '0;
                    r_cnt[i]  <= '0;
                end
            end
        end else if (i_cmd.abort) begin
            r_abort <= 1'b1;
        end else if (i_cmd.retire) begin
            if (r_rs < POOL_CNT) r_rs <= r_rs + 1'b1;
            r_wh    <= r_wh + 1'b1;
            r_ws    <= r_ws - 1'b1;
            r_start <= r_start + SEQ_W'(ppb_eff);
        end else if (i_cmd.count) begin
            r_cnt[cnt_id] <= cnt_new;
        end else if (i_cmd.exec) begin
            case (r_func)
                FUNC_READ: begin
                    if (!r_abort && r_rs != '0) begin
                        r_rh <= r_rh + 1'b1;
                        r_rs <= r_rs - 1'b1;
                    end
                end
                FUNC_RELEASE: begin
                    if (!r_abort && r_ws < POOL_CNT) begin
                        r_cnt[r_rel] <= '0;
                        r_wids[r_wh + r_ws[ID_W-1:0]] <= r_rel;
                        r_ws <= r_ws + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // readable id store
    always_ff @(posedge i_clk) begin
        if (i_cmd.retire && r_rs < POOL_CNT) begin
            r_rids[r_rh + r_rs[ID_W-1:0]] <= r_wids[r_wh];
        end
    end

    // word registers, divider and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_rel       <= i_released_buffer;
            r_dq        <= (i_sequence_req > r_start) ? i_sequence_req - r_start : '0;
            r_rem       <= '0;
            r_dcnt      <= '0;
            r_ret       <= '0;
            r_s_status  <= ST_OK;
            r_s_slot    <= '0;
            r_s_count   <= '0;
            r_s_missing <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= qbit ? trial - {1'b0, ppb_eff} : trial;
            r_dq   <= {r_dq[SEQ_W-2:0], qbit};
            r_dcnt <= r_dcnt + 1'b1;
        end else if (i_cmd.abort) begin
            r_s_status <= ST_ABORT;
        end else if (i_cmd.retire) begin
            r_dq[SIZE_W-1:0] <= r_dq[SIZE_W-1:0] - 1'b1;
            r_ret <= r_ret + 1'b1;
        end else if (i_cmd.count) begin
            r_s_slot  <= cnt_id;
            r_s_count <= cnt_new;
        end else if (i_cmd.exec) begin
            case (r_func)
                FUNC_READ: begin
                    if (r_abort) begin
                        r_s_status <= ST_ABORT;
                    end else if (r_rs == '0) begin
                        r_s_status <= ST_EMPTY;
                    end else begin
                        r_s_slot    <= rd_id;
                        r_s_count   <= r_cnt[rd_id];
                        r_s_missing <= {1'b0, r_ppb} - {1'b0, r_cnt[rd_id]};
                    end
                end
                FUNC_RELEASE: begin
                    r_s_slot <= r_rel;
                    if (r_abort || r_ws >= POOL_CNT) r_s_status <= ST_DROPPED;
                end
                default: ;
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status          <= r_s_status;
            o_buffer_slot     <= r_s_slot;
            o_packet_count    <= r_s_count;
            o_missing_pkts    <= r_s_missing;
            o_retired         <= r_ret;
            o_writable_count  <= r_ws;
            o_readable_count  <= r_rs;
        end
    end

endmodule

### dv/psbp_checker.sv
// checker for the buffer placer: predicts each result word and compares it
module psbp_checker import psbp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [1:0]         i_func,
    input  logic [SEQ_W-1:0]   i_sequence_req,
    input  logic [ID_W-1:0]    i_released_buffer,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [ID_W-1:0]    i_buffer_slot,
    input  logic [CNT_W-1:0]   i_packet_count,
    input  logic [16:0]        i_missing_pkts,
    input  logic [2:0]         i_retired,
    input  logic [SIZE_W-1:0]  i_writable_count,
    input  logic [SIZE_W-1:0]  i_readable_count,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output int                 o_fails,
    output int                 o_pending,
    output logic [SEQ_W-1:0]   o_start_seq
);

    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   slot;
        logic [CNT_W-1:0]  count;
        logic [16:0]       missing;
        logic [2:0]        retired;
        logic [SIZE_W-1:0] wr_cnt;
        logic [SIZE_W-1:0] rd_cnt;
    } t_word;

    t_word            expected_words[EXP_DEPTH];
    int               exp_rd, exp_wr, exp_n;
    logic [CNT_W-1:0] ppb;
    logic [SIZE_W-1:0] biu;
    logic [ID_W-1:0]  wr_ids[POOL_SIZE];
    logic [ID_W-1:0]  rd_ids[POOL_SIZE];
    logic [CNT_W-1:0] pkt_cnt[POOL_SIZE];
    int               wr_head, wr_size, rd_head, rd_size;
    logic [SEQ_W-1:0] start_seq;
    logic             aborted;
    int               fails;

    task automatic rebuild_pool();
        int n;
        n = (biu > POOL_SIZE) ? POOL_SIZE : int'(biu);
        for (int i = 0; i < POOL_SIZE; i++) begin
            wr_ids[i] = (i < n) ? ID_W'(i) : '0;
            rd_ids[i] = '0;
            pkt_cnt[i] = '0;
        end
        wr_head = 0;
        wr_size = n;
        rd_head = 0;
        rd_size = 0;
        start_seq = '0;
        aborted = 1'b0;
    endtask

    task automatic place_word(input logic [1:0] fn, input logic [SEQ_W-1:0] sq,
                              input logic [ID_W-1:0] rel, output t_word w);
        logic [63:0]      ppb_eff;
        logic [63:0]      idx;
        logic [SEQ_W-1:0] diff;
        logic [ID_W-1:0]  id;
        w = '0;
        ppb_eff = (ppb == 0) ? 64'd1 : 64'(ppb);
        if (fn == FUNC_PACKET) begin
            idx = 0;
            if (sq > start_seq) begin
                diff = sq - start_seq;
                idx = 64'(diff) / ppb_eff;
            end
            if (idx >= 64'(wr_size)) begin
                aborted = 1'b1;
                w.status = ST_ABORT;
            end else begin
                while (idx > 64'(RETIRE_LIMIT)) begin
                    if (rd_size < POOL_SIZE) begin
                        rd_ids[(rd_head + rd_size) % POOL_SIZE] = wr_ids[wr_head];
                        rd_size++;
                    end
                    wr_head = (wr_head + 1) % POOL_SIZE;
                    wr_size--;
                    start_seq = start_seq + SEQ_W'(ppb_eff);
                    idx--;
                    w.retired = w.retired + 3'd1;
                end
                id = wr_ids[(wr_head + int'(idx)) % POOL_SIZE];
                if (pkt_cnt[id] != 16'hFFFF) pkt_cnt[id] = pkt_cnt[id] + 16'd1;
                w.slot = id;
                w.count = pkt_cnt[id];
            end
        end else if (fn == FUNC_READ) begin
            if (aborted) begin
                w.status = ST_ABORT;
            end else if (rd_size == 0) begin
                w.status = ST_EMPTY;
            end else begin
                id = rd_ids[rd_head];
                rd_head = (rd_head + 1) % POOL_SIZE;
                rd_size--;
                w.slot = id;
                w.count = pkt_cnt[id];
                w.missing = {1'b0, ppb} - {1'b0, pkt_cnt[id]};
            end
        end else if (fn == FUNC_RELEASE) begin
            w.slot = rel;
            if (aborted || wr_size >= POOL_SIZE) begin
                w.status = ST_DROPPED;
            end else begin
                pkt_cnt[rel] = '0;
                wr_ids[(wr_head + wr_size) % POOL_SIZE] = rel;
                wr_size++;
            end
        end
        w.wr_cnt = SIZE_W'(wr_size);
        w.rd_cnt = SIZE_W'(rd_size);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            ppb = PPB_RESET;
            biu = BIU_RESET;
            rebuild_pool();
            exp_rd = 0;
            exp_wr = 0;
            exp_n = 0;
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PPB) begin
                    ppb = i_cfg_data;
                end else begin
                    biu = i_cfg_data[SIZE_W-1:0];
                    rebuild_pool();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (exp_n == 0) begin
                    $display("%0t: unexpected result word, actual status %0h slot %0h",
                             $time, i_status, i_buffer_slot);
                    fails++;
                end else begin
                    w = expected_words[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_n--;
                    check_field("status", 64'(w.status), 64'(i_status));
                    check_field("buffer_slot", 64'(w.slot), 64'(i_buffer_slot));
                    check_field("packet_count", 64'(w.count), 64'(i_packet_count));
                    check_field("missing_pkts", 64'(w.missing), 64'(i_missing_pkts));
                    check_field("retired", 64'(w.retired), 64'(i_retired));
                    check_field("writable_count", 64'(w.wr_cnt), 64'(i_writable_count));
                    check_field("readable_count", 64'(w.rd_cnt), 64'(i_readable_count));
                end
            end
            if (i_valid && !i_stall_in) begin
                place_word(i_func, i_sequence_req, i_released_buffer, w);
                expected_words[exp_wr] = w;
                exp_wr = (exp_wr + 1) % EXP_DEPTH;
                exp_n++;
            end
        end
        o_fails     <= fails;
        o_pending   <= exp_n;
        o_start_seq <= start_seq;
    end

endmodule

### dv/packet_sequence_buffer_placer_tb.sv
// testbench top for the buffer placer: stimulus, idling and verdict
module packet_sequence_buffer_placer_tb;
    import psbp_pkg::*;

    localparam int LIMIT = 3000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_func = FUNC_NOP;
    logic [SEQ_W-1:0]   i_sequence_req = '0;
    logic [ID_W-1:0]    i_released_buffer = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic [ID_W-1:0]    o_buffer_slot;
    logic [CNT_W-1:0]   o_packet_count;
    logic signed [16:0] o_missing_pkts;
    logic [2:0]         o_retired;
    logic [SIZE_W-1:0]  o_writable_count;
    logic [SIZE_W-1:0]  o_readable_count;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_PPB;
    logic [CNT_W-1:0]   i_cfg_data = '0;

    int               fails, pending;
    logic [SEQ_W-1:0] start_seq;
    int               gap_pct = 0, stall_pct = 0;
    int               hold_asked = 0, hold_seen = 0, hold_left = 0;
    int               cycles = 0;
    logic [CNT_W-1:0] cur_ppb;

    packet_sequence_buffer_placer DUT (.*);

    psbp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_func(i_func),
        .i_sequence_req(i_sequence_req), .i_released_buffer(i_released_buffer),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_buffer_slot(o_buffer_slot),
        .i_packet_count(o_packet_count), .i_missing_pkts(o_missing_pkts),
        .i_retired(o_retired), .i_writable_count(o_writable_count),
        .i_readable_count(o_readable_count),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fails(fails), .o_pending(pending), .o_start_seq(start_seq)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_word(input logic [1:0] fn, input logic [SEQ_W-1:0] sq,
                             input logic [ID_W-1:0] rel);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < gap_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_sequence_req <= sq;
        i_released_buffer <= rel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] ppb, input logic [SIZE_W-1:0] biu);
        wait_drained();
        cur_ppb = ppb;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PPB;
        i_cfg_data <= ppb;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_BIU;
        i_cfg_data <= CNT_W'(biu);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_word();
        int               r;
        logic [31:0]      ppbe;
        logic [SEQ_W-1:0] sq;
        r = $urandom_range(0, 99);
        ppbe = (cur_ppb == 0) ? 32'd1 : 32'(cur_ppb);
        if (r < 50) begin
            if ($urandom_range(0, 9) == 0)
                sq = start_seq - SEQ_W'($urandom_range(0, 5));
            else
                sq = start_seq + SEQ_W'($urandom_range(0, 4 * ppbe - 1));
            send_word(FUNC_PACKET, sq, ID_W'($urandom));
        end else if (r < 51) begin
            send_word(FUNC_PACKET, SEQ_W'({$urandom, $urandom}), ID_W'($urandom));
        end else if (r < 73) begin
            send_word(FUNC_READ, SEQ_W'({$urandom, $urandom}), ID_W'($urandom));
        end else if (r < 96) begin
            send_word(FUNC_RELEASE, SEQ_W'({$urandom, $urandom}), ID_W'($urandom));
        end else begin
            send_word(FUNC_NOP, SEQ_W'({$urandom, $urandom}), ID_W'($urandom));
        end
    endtask

    initial begin
        logic [CNT_W-1:0]  ppb;
        logic [SIZE_W-1:0] biu;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words
        configure(16'd4, 4'd8);
        send_word(FUNC_PACKET, 48'd0, 3'd0);
        send_word(FUNC_PACKET, 48'd5, 3'd0);
        send_word(FUNC_PACKET, 48'd11, 3'd0);
        send_word(FUNC_PACKET, 48'd14, 3'd0);
        send_word(FUNC_PACKET, 48'd30, 3'd0);
        send_word(FUNC_READ, 48'd0, 3'd0);
        send_word(FUNC_READ, 48'd0, 3'd0);
        send_word(FUNC_READ, 48'd0, 3'd0);
        send_word(FUNC_RELEASE, 48'd0, 3'd7);
        send_word(FUNC_RELEASE, 48'd0, 3'd0);
        send_word(FUNC_NOP, 48'hFFFF_FFFF_FFFF, 3'd7);
        send_word(FUNC_PACKET, 48'd3, 3'd0);
        send_word(FUNC_PACKET, 48'hFFFF_FFFF_FFFF, 3'd0);
        send_word(FUNC_PACKET, 48'd14, 3'd0);
        send_word(FUNC_READ, 48'd0, 3'd0);
        send_word(FUNC_RELEASE, 48'd0, 3'd2);
        configure(16'd0, 4'd0);
        send_word(FUNC_PACKET, 48'd0, 3'd0);
        send_word(FUNC_READ, 48'd0, 3'd0);
        configure(16'hFFFF, 4'd15);
        send_word(FUNC_PACKET, 48'd0, 3'd0);
        send_word(FUNC_PACKET, 48'd262140, 3'd0);
        send_word(FUNC_READ, 48'd0, 3'd0);
        configure(16'd1, 4'd3);
        send_word(FUNC_PACKET, 48'd2, 3'd0);
        send_word(FUNC_PACKET, 48'd3, 3'd0);

        // random phases
        for (int ph = 0; ph < 13; ph++) begin
            case (ph % 13)
                0: ppb = 16'd1;
                5: ppb = 16'hFFFF;
                9: ppb = 16'd0;
                default: ppb = ($urandom_range(0, 5) == 0) ? CNT_W'($urandom)
                                                           : CNT_W'($urandom_range(1, 16));
            endcase
            case (ph % 13)
                1: biu = 4'd3;
                2: biu = 4'd8;
                7: biu = 4'd15;
                11: biu = SIZE_W'($urandom_range(0, 2));
                default: biu = SIZE_W'($urandom_range(3, 8));
            endcase
            configure(ppb, biu);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 85; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 85; end
                default: begin gap_pct = 9; stall_pct = 9; end
            endcase
            for (int k = 0; k < 150; k++) begin
                if (ph == 3 && k == 20) hold_asked++;
                if (ph == 6 && k == 75) wait_drained();
                random_word();
            end
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
design/psbp_pkg.sv
design/psbp_ctrl.sv
design/psbp_dp.sv
design/packet_sequence_buffer_placer.sv
dv/psbp_checker.sv
dv/packet_sequence_buffer_placer_tb.sv
